// ===== design/inms_pkg.sv =====
package inms_pkg;

  // Field widths of the pixel and result words.
  localparam int MAG_W  = 19;
  localparam int GRAD_W = 19;
  localparam int ANG_W  = 17;
  localparam int ROW_W  = 16;

  // Configuration port and register widths.
  localparam int WREG_W = 11;
  localparam int HREG_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Reset values and limits.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 16'd1024;
  localparam int MIN_DIM = 3;

  // Weight and comparison arithmetic.
  localparam int WT_W   = 16;
  localparam int REM_W  = MAG_W + 1;
  localparam int DIFF_W = MAG_W + 1;
  localparam int PROD_W = DIFF_W + WT_W + 1;
  localparam int CMP_W  = PROD_W + 1;

  // Angle limits in degrees times 256.
  localparam logic signed [ANG_W-1:0] DEG45  = 17'sd11520;
  localparam logic signed [ANG_W-1:0] DEG90  = 17'sd23040;
  localparam logic signed [ANG_W-1:0] DEG135 = 17'sd34560;
  localparam logic signed [ANG_W-1:0] DEG180 = 17'sd46080;

  typedef enum logic [1:0] {
    SEC_A,
    SEC_B,
    SEC_C,
    SEC_D
  } sector_e;

  typedef struct packed {
    logic    hit;
    sector_e sec;
  } sector_t;

  // One entry of the middle line memory.
  typedef struct packed {
    logic        [MAG_W-1:0]  mag;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [ANG_W-1:0]  ang;
  } mid_t;

  // Picks the interpolation sector of an angle; no hit outside +-180 degrees.
  function automatic sector_t angle_sector(logic signed [ANG_W-1:0] t);
    sector_t s;
    s.hit = 1'b1;
    s.sec = SEC_A;
    if ((t >= 17'sd0 && t <= DEG45) || (t >= -DEG180 && t < -DEG135)) begin
      s.sec = SEC_A;
    end else if ((t > DEG45 && t <= DEG90) || (t >= -DEG135 && t < -DEG90)) begin
      s.sec = SEC_B;
    end else if ((t > DEG90 && t <= DEG135) || (t >= -DEG90 && t < -DEG45)) begin
      s.sec = SEC_C;
    end else if ((t > DEG135 && t <= DEG180) || (t >= -DEG45 && t < 17'sd0)) begin
      s.sec = SEC_D;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // Magnitude of a signed gradient.
  function automatic logic [GRAD_W-1:0] grad_abs(logic signed [GRAD_W-1:0] v);
    return v[GRAD_W-1] ? GRAD_W'(-v) : GRAD_W'(v);
  endfunction

endpackage

// ===== design/inms_pix_if.sv =====
interface inms_pix_if;
  logic                               valid;
  logic                               ready;
  logic        [inms_pkg::MAG_W-1:0]  magnitude;
  logic signed [inms_pkg::GRAD_W-1:0] grad_x;
  logic signed [inms_pkg::GRAD_W-1:0] grad_y;
  logic signed [inms_pkg::ANG_W-1:0]  angle;

  modport source (output valid, magnitude, grad_x, grad_y, angle, input ready);
  modport sink (input valid, magnitude, grad_x, grad_y, angle, output ready);
endinterface

// ===== design/inms_res_if.sv =====
interface inms_res_if #(
  parameter int COL_W = 10
);
  logic                        valid;
  logic                        ready;
  logic [inms_pkg::MAG_W-1:0]  suppressed_magnitude;
  logic [inms_pkg::ROW_W-1:0]  out_row;
  logic [COL_W-1:0]            out_col;

  modport source (output valid, suppressed_magnitude, out_row, out_col, input ready);
  modport sink (input valid, suppressed_magnitude, out_row, out_col, output ready);
endinterface

// ===== design/interpolated_non_maximum_suppression_unit.sv =====
// Interpolated non-maximum suppression over a raster stream of gradient pixels.
// Pixels enter on pix_i (magnitude, grad_x, grad_y, angle), one word per pixel in
// raster order. For every interior pixel one word leaves on res_o: the centre
// magnitude if it is a local maximum along its interpolated gradient direction,
// else zero, with its row and column. Border pixels give no word.
// Throughput: one pixel per cycle while the skid register is free. The line
// memories are read when a pixel is accepted and written back when stage 1
// moves on; the weight comes from a 16-stage pipelined divider, one quotient
// bit per stage.
// Image width and height are to be written on the cfg port only while the unit
// is idle; the unit itself does not enforce this.
// Reset clears the counters, the pipeline valids and the output buffer and sets
// width and height to 1024; line memory contents are undefined until written by
// the first rows of a frame, so no clearing pass is needed.
// When the receiver stalls, a skid register takes one more word; the pipeline
// then holds and pix_i.ready drops until the skid register drains.
module interpolated_non_maximum_suppression_unit #(
  parameter int MAX_WIDTH = inms_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [inms_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [inms_pkg::CFG_W-1:0]   cfg_data_i,
  inms_pix_if.sink                     pix_i,
  inms_res_if.source                   res_o
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CLW   = (AW + 1 > inms_pkg::WREG_W) ? AW + 1 : inms_pkg::WREG_W;
  localparam int MAG_W = inms_pkg::MAG_W;
  localparam int WT_W  = inms_pkg::WT_W;
  localparam int REM_W = inms_pkg::REM_W;
  localparam int ROW_W = inms_pkg::ROW_W;

  typedef struct packed {
    logic             kill;
    logic             sat;
    logic [REM_W-1:0] rem;
    logic [WT_W-1:0]  quo;
    logic [MAG_W-1:0] g;
    logic [MAG_W-1:0] p1;
    logic [MAG_W-1:0] q1;
    logic [MAG_W-1:0] p2;
    logic [MAG_W-1:0] q2;
    logic [ROW_W-1:0] row;
    logic [AW-1:0]    col;
  } dstage_t;

  typedef struct packed {
    logic                                   kill;
    logic [MAG_W-1:0]                       g;
    logic [MAG_W-1:0]                       p1;
    logic [MAG_W-1:0]                       p2;
    logic signed [inms_pkg::PROD_W-1:0]     prod1;
    logic signed [inms_pkg::PROD_W-1:0]     prod2;
    logic [ROW_W-1:0]                       row;
    logic [AW-1:0]                          col;
  } mstage_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ROW_W-1:0] row;
    logic [AW-1:0]    col;
  } res_t;

  // Configuration registers.
  logic [inms_pkg::WREG_W-1:0] width_q;
  logic [inms_pkg::HREG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= inms_pkg::WIDTH_RESET;
      height_q <= inms_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        inms_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[inms_pkg::WREG_W-1:0];
        inms_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[inms_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: everything moves while the skid register is free.
  logic skid_v_q, out_v_q, en, acc;
  assign en          = !skid_v_q;
  assign pix_i.ready = en;
  assign acc         = pix_i.valid && en;

  // Clamped limits and raster counters.
  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [CLW-1:0]   wreg, wlim;
  logic [ROW_W-1:0] hlim;
  logic             col_end, row_end, produce;

  always_comb begin
    wreg = CLW'(width_q);
    if (wreg < CLW'(inms_pkg::MIN_DIM)) begin
      wlim = CLW'(inms_pkg::MIN_DIM);
    end else if (wreg > CLW'(MAX_WIDTH)) begin
      wlim = CLW'(MAX_WIDTH);
    end else begin
      wlim = wreg;
    end
    hlim    = (height_q < ROW_W'(inms_pkg::MIN_DIM)) ? ROW_W'(inms_pkg::MIN_DIM) : height_q;
    col_end = (CLW'(col_q) + CLW'(1)) >= wlim;
    row_end = ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(hlim);
    produce = (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Stage 1: pixel held while the line memories are read.
  logic                  s1_v_q, s1_prod_q;
  inms_pkg::mid_t        s1_pix_q;
  logic [AW-1:0]         s1_col_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic [AW-1:0]         s1_ocol_q;
  logic                  s1_adv;

  assign s1_adv = s1_v_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_prod_q     <= produce;
      s1_pix_q.mag  <= pix_i.magnitude;
      s1_pix_q.gx   <= pix_i.grad_x;
      s1_pix_q.gy   <= pix_i.grad_y;
      s1_pix_q.ang  <= pix_i.angle;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q - ROW_W'(1);
      s1_ocol_q     <= col_q - AW'(1);
    end
  end

  // Line memories: read at acceptance, written back when stage 1 moves on.
  logic [MAG_W-1:0] mem_up [0:MAX_WIDTH-1];
  inms_pkg::mid_t   mem_mid [0:MAX_WIDTH-1];
  logic [MAG_W-1:0] rd_up_q;
  inms_pkg::mid_t   rd_mid_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_up_q <= mem_up[col_q];
    end
    if (s1_adv) begin
      mem_up[s1_col_q] <= rd_mid_q.mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_mid_q <= mem_mid[col_q];
    end
    if (s1_adv) begin
      mem_mid[s1_col_q] <= s1_pix_q;
    end
  end

  // Window shift and sector selection.
  logic [MAG_W-1:0]                   win_q [0:8];
  logic [MAG_W-1:0]                   win_d [0:8];
  logic signed [inms_pkg::GRAD_W-1:0] held_gx_q, held_gy_q;
  logic signed [inms_pkg::ANG_W-1:0]  held_ang_q;
  inms_pkg::sector_t                  sec;
  logic [MAG_W-1:0]                   num;
  dstage_t                            sel;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3+1];
      win_d[k*3 + 1] = win_q[k*3+2];
    end
    win_d[2] = rd_up_q;
    win_d[5] = rd_mid_q.mag;
    win_d[8] = s1_pix_q.mag;
  end

  always_comb begin
    sec     = inms_pkg::angle_sector(held_ang_q);
    sel.g   = win_d[4];
    sel.row = s1_row_q;
    sel.col = s1_ocol_q;
    sel.quo = '0;
    unique case (sec.sec)
      inms_pkg::SEC_A: begin
        num = inms_pkg::grad_abs(held_gy_q);
        sel.p1 = win_d[3]; sel.q1 = win_d[0]; sel.p2 = win_d[5]; sel.q2 = win_d[8];
      end
      inms_pkg::SEC_B: begin
        num = inms_pkg::grad_abs(held_gx_q);
        sel.p1 = win_d[1]; sel.q1 = win_d[0]; sel.p2 = win_d[7]; sel.q2 = win_d[8];
      end
      inms_pkg::SEC_C: begin
        num = inms_pkg::grad_abs(held_gx_q);
        sel.p1 = win_d[1]; sel.q1 = win_d[2]; sel.p2 = win_d[7]; sel.q2 = win_d[6];
      end
      default: begin
        num = inms_pkg::grad_abs(held_gy_q);
        sel.p1 = win_d[5]; sel.q1 = win_d[2]; sel.p2 = win_d[3]; sel.q2 = win_d[6];
      end
    endcase
    sel.kill = (win_d[4] == '0) || !sec.hit;
    sel.sat  = num >= win_d[4];
    sel.rem  = REM_W'(num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      held_gx_q  <= rd_mid_q.gx;
      held_gy_q  <= rd_mid_q.gy;
      held_ang_q <= rd_mid_q.ang;
    end
  end

  // Divider pipeline: one quotient bit of |g| * 2^16 / G per stage.
  logic    dv_v_q [0:WT_W];
  dstage_t dv_q [0:WT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s1_v_q && s1_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= sel;
    end
  end

  for (genvar i = 0; i < WT_W; i++) begin : g_div
    logic [REM_W-1:0] sh;
    logic             ge;
    dstage_t          nxt;

    assign sh = {dv_q[i].rem[REM_W-2:0], 1'b0};
    assign ge = sh >= REM_W'(dv_q[i].g);

    always_comb begin
      nxt     = dv_q[i];
      nxt.rem = ge ? sh - REM_W'(dv_q[i].g) : sh;
      nxt.quo = {dv_q[i].quo[WT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[i+1] <= dv_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[i+1] <= nxt;
      end
    end
  end

  // Blend products (q - p) * w.
  logic [WT_W-1:0]                     wt;
  logic signed [inms_pkg::DIFF_W-1:0]  diff1, diff2;
  logic                                m_v_q;
  mstage_t                             m_q;

  assign wt    = dv_q[WT_W].sat ? '1 : dv_q[WT_W].quo;
  assign diff1 = $signed({1'b0, dv_q[WT_W].q1}) - $signed({1'b0, dv_q[WT_W].p1});
  assign diff2 = $signed({1'b0, dv_q[WT_W].q2}) - $signed({1'b0, dv_q[WT_W].p2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= dv_v_q[WT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q.kill  <= dv_q[WT_W].kill;
      m_q.g     <= dv_q[WT_W].g;
      m_q.p1    <= dv_q[WT_W].p1;
      m_q.p2    <= dv_q[WT_W].p2;
      m_q.prod1 <= diff1 * $signed({1'b0, wt});
      m_q.prod2 <= diff2 * $signed({1'b0, wt});
      m_q.row   <= dv_q[WT_W].row;
      m_q.col   <= dv_q[WT_W].col;
    end
  end

  // Exact comparison of G * 2^16 against both blended values.
  logic signed [inms_pkg::CMP_W-1:0] lhs, rhs1, rhs2;
  logic                              keep, push;
  res_t                              res_d;

  always_comb begin
    lhs      = $signed(inms_pkg::CMP_W'({m_q.g, 16'h0000}));
    rhs1     = $signed(inms_pkg::CMP_W'({m_q.p1, 16'h0000}))
             + inms_pkg::CMP_W'(m_q.prod1);
    rhs2     = $signed(inms_pkg::CMP_W'({m_q.p2, 16'h0000}))
             + inms_pkg::CMP_W'(m_q.prod2);
    keep     = !m_q.kill && (lhs >= rhs1) && (lhs >= rhs2);
    res_d.mag = keep ? m_q.g : '0;
    res_d.row = m_q.row;
    res_d.col = m_q.col;
    push     = m_v_q && en;
  end

  // Output register with a skid register behind it.
  res_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || res_o.ready) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || res_o.ready) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid                = out_v_q;
  assign res_o.suppressed_magnitude = out_q.mag;
  assign res_o.out_row              = out_q.row;
  assign res_o.out_col              = out_q.col;

  // The skid register only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // Nothing arrives from the pipeline while the skid register is full.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !m_v_q || !push)
    else $error("word pushed into a full output buffer");

  // A finished non-saturated division leaves a remainder below the divisor.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[WT_W] && !dv_q[WT_W].kill && !dv_q[WT_W].sat)
      |-> (dv_q[WT_W].rem < REM_W'(dv_q[WT_W].g)))
    else $error("divider remainder not below divisor");

  // Emitted centres are interior pixels.
  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.row != '0) && (out_q.col != '0))
    else $error("border pixel emitted");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int COL_W      = 10;
  localparam int LINE_DEPTH = 1024;
  localparam int DRAIN_WAIT = 40;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1800;
  localparam int HOLD_LEN   = 300;
  localparam int LONG_LINE  = 256;

  // One pixel word and one result word as the predictor sees them.
  typedef struct {
    logic        [inms_pkg::MAG_W-1:0]  mag;
    logic signed [inms_pkg::GRAD_W-1:0] gx;
    logic signed [inms_pkg::GRAD_W-1:0] gy;
    logic signed [inms_pkg::ANG_W-1:0]  ang;
  } pixel_t;

  typedef struct {
    logic [inms_pkg::MAG_W-1:0] mag;
    logic [inms_pkg::ROW_W-1:0] row;
    logic [COL_W-1:0]           col;
  } nms_word_t;

  // One row of the directed table; fixed_valid marks a hand-typed result.
  typedef struct {
    int  mag;
    int  gx;
    int  gy;
    int  ang;
    bit  fixed_valid;
    int  fixed_mag;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [inms_pkg::IDX_W-1:0] cfg_idx;
  logic [inms_pkg::CFG_W-1:0] cfg_data;

  inms_pix_if pix ();
  inms_res_if #(.COL_W(COL_W)) res ();

  interpolated_non_maximum_suppression_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  // Predictor state: line buffers, 3x3 window, centre delay and counters.
  logic        [inms_pkg::MAG_W-1:0]  upper_mag [LINE_DEPTH];
  logic        [inms_pkg::MAG_W-1:0]  middle_mag [LINE_DEPTH];
  logic signed [inms_pkg::GRAD_W-1:0] middle_gx [LINE_DEPTH];
  logic signed [inms_pkg::GRAD_W-1:0] middle_gy [LINE_DEPTH];
  logic signed [inms_pkg::ANG_W-1:0]  middle_ang [LINE_DEPTH];
  logic        [inms_pkg::MAG_W-1:0]  win [9];
  logic signed [inms_pkg::GRAD_W-1:0] centre_gx;
  logic signed [inms_pkg::GRAD_W-1:0] centre_gy;
  logic signed [inms_pkg::ANG_W-1:0]  centre_ang;
  int unsigned pos_row;
  int unsigned pos_col;
  int unsigned dim_w;
  int unsigned dim_h;

  nms_word_t pending_words [$];
  int errors;
  int n_rand;
  int n_recv;
  bit tx_quiet;
  bit rx_quiet;
  bit held_once;

  dir_row_t dir_rows [25] = '{
    '{100, 0, 0, 0, 0, 0},
    '{369408, 261120, -261120, 46080, 0, 0},
    '{1, -261120, 261120, -46080, 0, 0},
    '{5000, 1, -1, -1, 0, 0},
    '{200, 0, 0, 0, 0, 0},
    '{300, 0, 0, 0, 0, 0},
    '{0, 100, 100, 0, 0, 0},
    '{800, 100, 50, 65535, 0, 0},
    '{369408, -5, 7, 0, 0, 0},
    '{50, 0, 0, 0, 0, 0},
    '{700, 0, 0, 0, 0, 0},
    '{900, 0, 0, -65536, 0, 0},
    // Centre of zero magnitude is decided here.
    '{1000, 261120, -261120, 11520, 1, 0},
    // Centre with an angle above 180 degrees.
    '{600, -261120, 261120, 23040, 1, 0},
    // Centre at full magnitude can never be beaten.
    '{1200, 300, -200, 34560, 1, 369408},
    '{10, 5, 5, 5, 0, 0},
    '{1500, -400, 600, 34560, 0, 0},
    // Centre with an angle below -180 degrees.
    '{400, 500, -100, 46080, 1, 0},
    '{2000, 1000, 1000, -46080, 0, 0},
    '{100, -1000, 20, -11520, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{3000, 77, -77, -23040, 0, 0},
    '{250, -3, 9, -34560, 0, 0},
    '{1800, 40, 40, 11521, 0, 0},
    '{60, 0, 0, 0, 0, 0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Interpolated decision for the current window centre.
  function automatic bit not_below(longint g, longint p, longint q, longint wt);
    return g * 65536 >= p * 65536 + (q - p) * wt;
  endfunction

  function automatic logic [inms_pkg::MAG_W-1:0] nms_decide();
    longint g, t, num, wt, p1, q1, p2, q2;
    inms_pkg::sector_e sec;
    g = longint'(win[4]);
    t = longint'(centre_ang);
    if (g == 0) return '0;
    if ((t >= 0 && t <= longint'(inms_pkg::DEG45)) ||
        (t >= -longint'(inms_pkg::DEG180) && t < -longint'(inms_pkg::DEG135))) begin
      sec = inms_pkg::SEC_A;
    end else if ((t > longint'(inms_pkg::DEG45) && t <= longint'(inms_pkg::DEG90)) ||
                 (t >= -longint'(inms_pkg::DEG135) && t < -longint'(inms_pkg::DEG90))) begin
      sec = inms_pkg::SEC_B;
    end else if ((t > longint'(inms_pkg::DEG90) && t <= longint'(inms_pkg::DEG135)) ||
                 (t >= -longint'(inms_pkg::DEG90) && t < -longint'(inms_pkg::DEG45))) begin
      sec = inms_pkg::SEC_C;
    end else if ((t > longint'(inms_pkg::DEG135) && t <= longint'(inms_pkg::DEG180)) ||
                 (t >= -longint'(inms_pkg::DEG45) && t < 0)) begin
      sec = inms_pkg::SEC_D;
    end else begin
      return '0;
    end
    if (sec == inms_pkg::SEC_A || sec == inms_pkg::SEC_D) begin
      num = longint'(centre_gy);
    end else begin
      num = longint'(centre_gx);
    end
    if (num < 0) num = -num;
    wt = (num <<< 16) / g;
    if (wt > 65535) wt = 65535;
    case (sec)
      inms_pkg::SEC_A: begin p1 = win[3]; q1 = win[0]; p2 = win[5]; q2 = win[8]; end
      inms_pkg::SEC_B: begin p1 = win[1]; q1 = win[0]; p2 = win[7]; q2 = win[8]; end
      inms_pkg::SEC_C: begin p1 = win[1]; q1 = win[2]; p2 = win[7]; q2 = win[6]; end
      default: begin p1 = win[5]; q1 = win[2]; p2 = win[3]; q2 = win[6]; end
    endcase
    if (not_below(g, p1, q1, wt) && not_below(g, p2, q2, wt)) return win[4];
    return '0;
  endfunction

  // Advances the predictor by one accepted pixel and queues its result, if any.
  task automatic nms_step(input pixel_t p, input bit fixed_valid,
                          input logic [inms_pkg::MAG_W-1:0] fixed_mag);
    int unsigned w, h, c;
    logic [inms_pkg::MAG_W-1:0] up_v, mid_v;
    nms_word_t e;
    w = (dim_w < 3) ? 3 : ((dim_w > LINE_DEPTH) ? LINE_DEPTH : dim_w);
    h = (dim_h < 3) ? 3 : dim_h;
    c = pos_col % LINE_DEPTH;
    up_v = upper_mag[c];
    mid_v = middle_mag[c];
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up_v;
    win[5] = mid_v;
    win[8] = p.mag;
    if (pos_row >= 2 && pos_col >= 2) begin
      e.mag = fixed_valid ? fixed_mag : nms_decide();
      e.row = inms_pkg::ROW_W'(pos_row - 1);
      e.col = COL_W'(pos_col - 1);
      pending_words = {pending_words, e};
    end
    centre_gx = middle_gx[c];
    centre_gy = middle_gy[c];
    centre_ang = middle_ang[c];
    upper_mag[c] = mid_v;
    middle_mag[c] = p.mag;
    middle_gx[c] = p.gx;
    middle_gy[c] = p.gy;
    middle_ang[c] = p.ang;
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Writes both size registers, one per clock.
  task automatic set_dims(input int unsigned w, input int unsigned h);
    cfg_we <= 1'b1;
    cfg_idx <= inms_pkg::REG_IMAGE_WIDTH;
    cfg_data <= inms_pkg::CFG_W'(w);
    @(posedge clk_i);
    cfg_idx <= inms_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= inms_pkg::CFG_W'(h);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    dim_w = w;
    dim_h = h;
  endtask

  task automatic send_pixel(input pixel_t p, input bit fixed_valid,
                            input logic [inms_pkg::MAG_W-1:0] fixed_mag);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.magnitude <= p.mag;
    pix.grad_x <= p.gx;
    pix.grad_y <= p.gy;
    pix.angle <= p.ang;
    do @(posedge clk_i); while (!pix.ready);
    nms_step(p, fixed_valid, fixed_mag);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) p.mag = '0;
    else if (r < 45) p.mag = inms_pkg::MAG_W'($urandom_range(0, 369408));
    else p.mag = inms_pkg::MAG_W'($urandom_range(0, 4000));
    p.gx = inms_pkg::GRAD_W'(int'($urandom_range(0, 522240)) - 261120);
    p.gy = inms_pkg::GRAD_W'(int'($urandom_range(0, 522240)) - 261120);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      p.ang = inms_pkg::ANG_W'($urandom);
    end else if (r < 25) begin
      // Land on or next to a sector boundary.
      p.ang = inms_pkg::ANG_W'((int'($urandom_range(0, 8)) - 4) * 11520 +
                               int'($urandom_range(0, 2)) - 1);
    end else begin
      p.ang = inms_pkg::ANG_W'(int'($urandom_range(0, 92160)) - 46080);
    end
    return p;
  endfunction

  task automatic send_random(input int n);
    repeat (n) begin
      send_pixel(rand_pixel(), 1'b0, '0);
      n_rand++;
    end
  endtask

  // Fills out the current frame so that the next pixel starts a new one.
  task automatic finish_frame();
    while (pos_row != 0 || pos_col != 0) begin
      send_pixel(rand_pixel(), 1'b0, '0);
      n_rand++;
    end
  endtask

  // Waits until every expected word has come and the pipeline has gone quiet.
  task automatic drain();
    pix.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off, field-by-field compare.
  initial begin
    int gap;
    nms_word_t e;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_once && n_recv >= 60) begin
        held_once = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          res.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      n_recv++;
      if (n_recv % 50 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      if (pending_words.size() == 0) begin
        report("unexpected word, magnitude", res.suppressed_magnitude, -1);
      end else begin
        e = pending_words[0];
        pending_words.delete(0);
        if (res.suppressed_magnitude !== e.mag)
          report("suppressed_magnitude", res.suppressed_magnitude, e.mag);
        if (res.out_row !== e.row) report("out_row", res.out_row, e.row);
        if (res.out_col !== e.col) report("out_col", res.out_col, e.col);
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed frame, then extreme and random sizes.
  initial begin
    pixel_t p;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= inms_pkg::REG_IMAGE_WIDTH;
    cfg_data <= '0;
    pix.valid <= 1'b0;
    pix.magnitude <= '0;
    pix.grad_x <= '0;
    pix.grad_y <= '0;
    pix.angle <= '0;
    res.ready <= 1'b0;
    errors = 0;
    n_rand = 0;
    n_recv = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    held_once = 1'b0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_mag[i] = '0;
      middle_mag[i] = '0;
      middle_gx[i] = '0;
      middle_gy[i] = '0;
      middle_ang[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    centre_gx = '0;
    centre_gy = '0;
    centre_ang = '0;
    pos_row = 0;
    pos_col = 0;
    dim_w = 1024;
    dim_h = 1024;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_dims(5, 5);
    foreach (dir_rows[i]) begin
      p.mag = inms_pkg::MAG_W'(dir_rows[i].mag);
      p.gx = inms_pkg::GRAD_W'(dir_rows[i].gx);
      p.gy = inms_pkg::GRAD_W'(dir_rows[i].gy);
      p.ang = inms_pkg::ANG_W'(dir_rows[i].ang);
      send_pixel(p, dir_rows[i].fixed_valid, inms_pkg::MAG_W'(dir_rows[i].fixed_mag));
    end
    drain();

    // Smallest frame, a long line, and the tallest height left mid-frame.
    set_dims(3, 3);
    send_random(18);
    drain();
    tx_quiet = 1'b1;
    set_dims(LONG_LINE, 3);
    send_random(LONG_LINE * 3);
    drain();
    tx_quiet = 1'b0;
    set_dims(4, 65535);
    send_random(40);
    drain();
    set_dims(4, 3);
    finish_frame();
    drain();

    // Random sizes, whole frames only, with quiet stretches on the sender.
    while (n_rand + $size(dir_rows) < RAND_ITEMS) begin
      int unsigned w, h;
      tx_quiet = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 14) : $urandom_range(15, 64);
      h = $urandom_range(3, 7);
      set_dims(w, h);
      send_random(w * h * $urandom_range(1, 2));
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/inms_pkg.sv
design/inms_pix_if.sv
design/inms_res_if.sv
design/interpolated_non_maximum_suppression_unit.sv
tb/tb_top.sv
